[rtl/tpc_pkg.sv]
// shared types and constants for the thermistor probe converter
// no dependencies; every other file but tpc_ram refers to it by scoped names
package tpc_pkg;

  // field and register widths
  localparam int PROBE_W  = 3;
  localparam int CODE_W   = 10;
  localparam int TEMP_W   = 16;
  localparam int SERIES_W = 20;
  localparam int COEF_W   = 48;
  localparam int PADDR_W  = 5;
  localparam int PDATA_W  = 64;
  localparam int REG_W    = 2;

  // register indexes
  localparam logic [REG_W-1:0] REG_SERIES = 2'd0;
  localparam logic [REG_W-1:0] REG_COEF_A = 2'd1;
  localparam logic [REG_W-1:0] REG_COEF_B = 2'd2;
  localparam logic [REG_W-1:0] REG_COEF_C = 2'd3;

  localparam logic [SERIES_W-1:0] SERIES_RESET = 20'd10000;

  // log2 unit
  localparam int LOG_FRAC = 24;
  localparam int MANT_W   = 31;
  localparam int NORM_STEP = 8;

  // shared multiplier: 48-bit magnitudes, 16-bit digits
  localparam int MAG_W      = 48;
  localparam int DIGIT_W    = 16;
  localparam int MUL_DIGITS = MAG_W / DIGIT_W;
  localparam int PROD_W     = 2 * MAG_W;

  // datapath value widths
  localparam int D_W  = 32;
  localparam int L_W  = 32;
  localparam int L2_W = 40;
  localparam int L3_W = 40;
  localparam int DV_W = 67;

  localparam logic [63:0] LN2_Q32   = 64'd2977044472;
  localparam logic [63:0] RECIP_NUM = 64'h9000_0000_0000_0000;
  localparam logic [63:0] INT64_MAX = 64'h7fff_ffff_ffff_ffff;
  localparam int OFFSET_Q4 = 117606;

  // sequencer steps
  localparam int STEP_W = 3;
  localparam logic [STEP_W-1:0] STEP_LOG_NUM = 3'd0;
  localparam logic [STEP_W-1:0] STEP_LOG_DEN = 3'd1;
  localparam logic [STEP_W-1:0] STEP_MUL_L   = 3'd2;
  localparam logic [STEP_W-1:0] STEP_MUL_L2  = 3'd3;
  localparam logic [STEP_W-1:0] STEP_MUL_L3  = 3'd4;
  localparam logic [STEP_W-1:0] STEP_MUL_B   = 3'd5;
  localparam logic [STEP_W-1:0] STEP_MUL_C   = 3'd6;
  localparam logic [STEP_W-1:0] STEP_DIV     = 3'd7;

  // controller to datapath
  typedef struct packed {
    logic              load;
    logic              read;
    logic              start;
    logic              store;
    logic              emit;
    logic [STEP_W-1:0] step;
  } tpc_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic idx_ok;
    logic rail;
    logic done;
  } tpc_status_t;

endpackage

[rtl/tpc_in_if.sv]
// sample channel: probe index and raw converter code
// depends on tpc_pkg
interface tpc_in_if;
  logic                         valid;
  logic                         ready;
  logic [tpc_pkg::PROBE_W-1:0]  probe_index;
  logic [tpc_pkg::CODE_W-1:0]   adc_code;

  modport source (output valid, probe_index, adc_code, input ready);
  modport sink (input valid, probe_index, adc_code, output ready);
endinterface

[rtl/tpc_out_if.sv]
// result channel: probe status, temperature and events
// depends on tpc_pkg
interface tpc_out_if;
  logic                               valid;
  logic                               ready;
  logic [tpc_pkg::PROBE_W-1:0]        probe_id;
  logic                               is_connected;
  logic signed [tpc_pkg::TEMP_W-1:0]  temperature_f;
  logic                               connect_event;
  logic                               disconnect_event;
  logic                               change_event;

  modport source (output valid, probe_id, is_connected, temperature_f, connect_event,
                  disconnect_event, change_event, input ready);
  modport sink (input valid, probe_id, is_connected, temperature_f, connect_event,
                disconnect_event, change_event, output ready);
endinterface

[rtl/tpc_ram.sv]
// generic single-port-write, registered-read ram
// no dependencies
module tpc_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 8,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               we,
  input  logic [AW-1:0]      waddr,
  input  logic [WIDTH-1:0]   wdata,
  input  logic               re,
  input  logic [AW-1:0]      raddr,
  output logic [WIDTH-1:0]   rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end
endmodule

[rtl/tpc_log2.sv]
// iterative log2 in q24: normalize shift then 24 squaring steps
// depends on tpc_pkg
module tpc_log2 #(
  parameter int W = 30,
  localparam int E_W = $clog2(W)
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [W-1:0]                 v,
  output logic                         done,
  output logic [E_W+tpc_pkg::LOG_FRAC-1:0] result
);
  localparam int CNT_W = $clog2(tpc_pkg::LOG_FRAC);

  logic                          busy;
  logic                          norm;
  logic [W-1:0]                  n;
  logic [W+tpc_pkg::MANT_W-1:0]  n_ext;
  logic [E_W-1:0]                e;
  logic [tpc_pkg::MANT_W-1:0]    m;
  logic [tpc_pkg::LOG_FRAC-1:0]  frac;
  logic [CNT_W-1:0]              cnt;
  logic [2*tpc_pkg::MANT_W-1:0]  sq;
  logic [tpc_pkg::MANT_W:0]      sq_hi;

  // mantissa square, q30
  assign sq    = m * m;
  assign sq_hi = sq[2*tpc_pkg::MANT_W-1 -: tpc_pkg::MANT_W+1];

  // normalized value padded below so the q30 window fits any width
  assign n_ext = {n, {tpc_pkg::MANT_W{1'b0}}};

  // normalize, then one fraction bit per squaring
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      norm <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        norm <= 1'b1;
        n    <= (v == '0) ? W'(1) : v;
        e    <= E_W'(W - 1);
        cnt  <= '0;
        frac <= '0;
      end else if (busy && norm) begin
        if (n[W-1]) begin
          norm <= 1'b0;
          m    <= n_ext[W+tpc_pkg::MANT_W-1 -: tpc_pkg::MANT_W];
        end else if (n[W-1 -: tpc_pkg::NORM_STEP] == '0) begin
          n <= n << tpc_pkg::NORM_STEP;
          e <= e - E_W'(tpc_pkg::NORM_STEP);
        end else begin
          n <= n << 1;
          e <= e - E_W'(1);
        end
      end else if (busy) begin
        if (sq_hi[tpc_pkg::MANT_W]) begin
          m    <= sq_hi[tpc_pkg::MANT_W:1];
          frac <= {frac[tpc_pkg::LOG_FRAC-2:0], 1'b1};
        end else begin
          m    <= sq_hi[tpc_pkg::MANT_W-1:0];
          frac <= {frac[tpc_pkg::LOG_FRAC-2:0], 1'b0};
        end
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(tpc_pkg::LOG_FRAC - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign result = {e, frac};
endmodule

[rtl/tpc_mul.sv]
// signed q multiply a*b >> s, digit-serial over 16-bit digits of b,
// truncated toward zero and saturated; depends on tpc_pkg
module tpc_mul (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [63:0] a,
  input  logic signed [63:0] b,
  input  logic               shift_32,
  output logic               done,
  output logic signed [63:0] result
);
  localparam int CNT_W = $clog2(tpc_pkg::MUL_DIGITS);
  localparam int SAT24 = 24 + 63;

  logic                          busy;
  logic                          neg;
  logic                          sh32;
  logic [tpc_pkg::MAG_W-1:0]     ma;
  logic [tpc_pkg::MAG_W-1:0]     mb;
  logic [tpc_pkg::PROD_W-1:0]    acc;
  logic [CNT_W-1:0]              cnt;
  logic [63:0]                   a_mag;
  logic [63:0]                   b_mag;
  logic [tpc_pkg::MAG_W+tpc_pkg::DIGIT_W-1:0] pp;
  logic                          sat;
  logic [63:0]                   r;
  logic [63:0]                   r_sat;

  assign a_mag = a[63] ? (~a + 64'd1) : a;
  assign b_mag = b[63] ? (~b + 64'd1) : b;
  assign pp    = ma * mb[tpc_pkg::MAG_W-1 -: tpc_pkg::DIGIT_W];

  // top digit first, shift and accumulate
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        ma   <= a_mag[tpc_pkg::MAG_W-1:0];
        mb   <= b_mag[tpc_pkg::MAG_W-1:0];
        neg  <= a[63] ^ b[63];
        sh32 <= shift_32;
        acc  <= '0;
        cnt  <= '0;
      end else if (busy) begin
        acc <= (acc << tpc_pkg::DIGIT_W) + tpc_pkg::PROD_W'(pp);
        mb  <= mb << tpc_pkg::DIGIT_W;
        cnt <= cnt + CNT_W'(1);
        if (cnt == CNT_W'(tpc_pkg::MUL_DIGITS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // select the shifted window, saturate, restore sign
  always_comb begin
    if (sh32) begin
      sat = acc[tpc_pkg::PROD_W-1];
      r   = acc[32 +: 64];
    end else begin
      sat = |acc[tpc_pkg::PROD_W-1:SAT24];
      r   = acc[24 +: 64];
    end
    r_sat  = sat ? tpc_pkg::INT64_MAX : r;
    result = neg ? -$signed(r_sat) : $signed(r_sat);
  end
endmodule

[rtl/tpc_ctrl.sv]
// controller: sample and result handshakes and the step sequencer
// depends on tpc_pkg
module tpc_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  output logic                  out_valid,
  input  logic                  out_ready,
  input  tpc_pkg::tpc_status_t  status,
  output tpc_pkg::tpc_cmd_t     cmd
);
  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_READ = 3'd1;
  localparam logic [2:0] ST_GO   = 3'd2;
  localparam logic [2:0] ST_WAIT = 3'd3;
  localparam logic [2:0] ST_FIN  = 3'd4;

  logic [2:0]                  state;
  logic [2:0]                  state_next;
  logic [tpc_pkg::STEP_W-1:0]  step;
  logic [tpc_pkg::STEP_W-1:0]  step_next;
  logic                        out_valid_next;

  // next state and commands
  always_comb begin
    state_next     = state;
    step_next      = step;
    out_valid_next = out_valid && !out_ready;
    in_ready       = 1'b0;
    cmd            = '0;
    cmd.step       = step;
    unique case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid && status.idx_ok) begin
          cmd.load   = 1'b1;
          state_next = ST_READ;
        end
      end
      ST_READ: begin
        cmd.read   = 1'b1;
        step_next  = tpc_pkg::STEP_LOG_NUM;
        state_next = status.rail ? ST_FIN : ST_GO;
      end
      ST_GO: begin
        cmd.start  = 1'b1;
        state_next = ST_WAIT;
      end
      ST_WAIT: begin
        if (status.done) begin
          cmd.store = 1'b1;
          if (step == tpc_pkg::STEP_DIV) begin
            state_next = ST_FIN;
          end else begin
            step_next  = step + tpc_pkg::STEP_W'(1);
            state_next = ST_GO;
          end
        end
      end
      ST_FIN: begin
        if (!out_valid || out_ready) begin
          cmd.emit       = 1'b1;
          out_valid_next = 1'b1;
          state_next     = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      step      <= tpc_pkg::STEP_LOG_NUM;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      step      <= step_next;
      out_valid <= out_valid_next;
    end
  end
endmodule

[rtl/tpc_dp.sv]
// datapath: divider ratio, log2 unit, shared multiplier, reciprocal divider,
// per-probe state ram and result registers; depends on tpc_pkg, tpc_ram,
// tpc_log2, tpc_mul
module tpc_dp #(
  parameter int PROBES   = 8,
  parameter int ADC_BITS = 10
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  tpc_pkg::tpc_cmd_t                    cmd,
  output tpc_pkg::tpc_status_t                 status,
  input  logic [tpc_pkg::PROBE_W-1:0]          in_idx,
  input  logic [tpc_pkg::CODE_W-1:0]           in_code,
  input  logic [tpc_pkg::SERIES_W-1:0]         series,
  input  logic signed [tpc_pkg::COEF_W-1:0]    coef_a,
  input  logic signed [tpc_pkg::COEF_W-1:0]    coef_b,
  input  logic signed [tpc_pkg::COEF_W-1:0]    coef_c,
  output logic [tpc_pkg::PROBE_W-1:0]          probe_id,
  output logic                                 is_connected,
  output logic signed [tpc_pkg::TEMP_W-1:0]    temperature_f,
  output logic                                 connect_event,
  output logic                                 disconnect_event,
  output logic                                 change_event
);
  localparam int AW     = (PROBES > 1) ? $clog2(PROBES) : 1;
  localparam int W      = tpc_pkg::SERIES_W + ADC_BITS;
  localparam int LOG_W  = $clog2(W) + tpc_pkg::LOG_FRAC;
  localparam int ST_W   = tpc_pkg::TEMP_W + 1;
  localparam int DCNT_W = 6;
  localparam int DV_W_L = tpc_pkg::DV_W;
  localparam logic [ADC_BITS-1:0] FULL_SCALE = {ADC_BITS{1'b1}};

  logic [tpc_pkg::PROBE_W-1:0]      idx;
  logic [AW-1:0]                    addr;
  logic [ADC_BITS-1:0]              code;
  logic [ADC_BITS-1:0]              code_in;
  logic                             rail;
  logic [W-1:0]                     rprod;
  logic [tpc_pkg::SERIES_W-1:0]     r_eff;
  logic [LOG_W-1:0]                 log_a;
  logic signed [tpc_pkg::D_W-1:0]   d;
  logic signed [tpc_pkg::L_W-1:0]   l;
  logic signed [tpc_pkg::L2_W-1:0]  l2;
  logic signed [tpc_pkg::L3_W-1:0]  l3;
  logic signed [63:0]               y;
  logic signed [tpc_pkg::TEMP_W-1:0] temp;
  logic [PROBES-1:0]                valid;

  logic                             log_start;
  logic [W-1:0]                     log_v;
  logic                             log_done;
  logic [LOG_W-1:0]                 log_res;
  logic                             mul_start;
  logic signed [63:0]               mul_a;
  logic signed [63:0]               mul_b;
  logic                             mul_sh32;
  logic                             mul_done;
  logic signed [63:0]               mul_res;

  logic                             div_start;
  logic                             div_busy;
  logic                             div_done;
  logic [DCNT_W-1:0]                div_cnt;
  logic [DV_W_L-1:0]                dvs;
  logic [DV_W_L-1:0]                rem;
  logic [63:0]                      quo;
  logic [DV_W_L:0]                  rem_sh;
  logic                             ge;
  logic [63:0]                      y_mag;
  logic signed [65:0]               q_s;
  logic signed [65:0]               t_full;
  logic signed [65:0]               t_sh;
  logic signed [tpc_pkg::TEMP_W-1:0] t_final;

  logic                             ram_we;
  logic [ST_W-1:0]                  ram_wdata;
  logic [ST_W-1:0]                  ram_rdata;
  logic                             was;
  logic signed [tpc_pkg::TEMP_W-1:0] old_t;
  logic                             now;

  // input decode
  assign code_in       = ADC_BITS'(in_code);
  assign status.idx_ok = 32'(in_idx) < PROBES;
  assign status.rail   = rail;
  assign status.done   = log_done | mul_done | div_done;
  assign addr          = AW'(idx);
  assign r_eff         = (series == '0) ? tpc_pkg::SERIES_W'(1) : series;

  // unit launch and operand routing
  always_comb begin
    log_start = 1'b0;
    mul_start = 1'b0;
    div_start = 1'b0;
    log_v     = rprod;
    mul_a     = 64'(d);
    mul_b     = $signed(tpc_pkg::LN2_Q32);
    mul_sh32  = 1'b0;
    unique case (cmd.step)
      tpc_pkg::STEP_LOG_NUM: begin
        log_start = cmd.start;
      end
      tpc_pkg::STEP_LOG_DEN: begin
        log_start = cmd.start;
        log_v     = W'(FULL_SCALE - code);
      end
      tpc_pkg::STEP_MUL_L: begin
        mul_start = cmd.start;
        mul_sh32  = 1'b1;
      end
      tpc_pkg::STEP_MUL_L2: begin
        mul_start = cmd.start;
        mul_a     = 64'(l);
        mul_b     = 64'(l);
      end
      tpc_pkg::STEP_MUL_L3: begin
        mul_start = cmd.start;
        mul_a     = 64'(l2);
        mul_b     = 64'(l);
      end
      tpc_pkg::STEP_MUL_B: begin
        mul_start = cmd.start;
        mul_a     = 64'(coef_b);
        mul_b     = 64'(l);
      end
      tpc_pkg::STEP_MUL_C: begin
        mul_start = cmd.start;
        mul_a     = 64'(coef_c);
        mul_b     = 64'(l3);
      end
      tpc_pkg::STEP_DIV: begin
        div_start = cmd.start;
      end
      default: begin
        log_start = 1'b0;
      end
    endcase
  end

  tpc_log2 #(.W(W)) u_log2 (
    .clk    (clk),
    .rst    (rst),
    .start  (log_start),
    .v      (log_v),
    .done   (log_done),
    .result (log_res)
  );

  tpc_mul u_mul (
    .clk      (clk),
    .rst      (rst),
    .start    (mul_start),
    .a        (mul_a),
    .b        (mul_b),
    .shift_32 (mul_sh32),
    .done     (mul_done),
    .result   (mul_res)
  );

  // reciprocal divider, one quotient bit per cycle
  assign y_mag  = y[63] ? (~y + 64'd1) : y;
  assign rem_sh = {rem, quo[63]};
  assign ge     = rem_sh >= {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      div_busy <= 1'b0;
      div_done <= 1'b0;
    end else begin
      div_done <= 1'b0;
      if (div_start) begin
        div_busy <= 1'b1;
        dvs      <= {3'b000, y_mag} + {1'b0, y_mag, 2'b00};
        rem      <= '0;
        quo      <= tpc_pkg::RECIP_NUM;
        div_cnt  <= '0;
      end else if (div_busy) begin
        rem     <= ge ? DV_W_L'(rem_sh - {1'b0, dvs}) : rem_sh[DV_W_L-1:0];
        quo     <= {quo[62:0], ge};
        div_cnt <= div_cnt + DCNT_W'(1);
        if (div_cnt == '1) begin
          div_busy <= 1'b0;
          div_done <= 1'b1;
        end
      end
    end
  end

  // signed reciprocal minus offset, round to the nearest whole 1/16 and saturate
  always_comb begin
    q_s    = y[63] ? -$signed({2'b00, quo}) : $signed({2'b00, quo});
    t_full = q_s - 66'sd117606 + 66'sd8;
    t_sh   = t_full >>> 4;
    if (y == '0) begin
      t_final = 16'sh7fff;
    end else if (t_sh > 66'sd32767) begin
      t_final = 16'sh7fff;
    end else if (t_sh < -66'sd32768) begin
      t_final = -16'sh8000;
    end else begin
      t_final = t_sh[tpc_pkg::TEMP_W-1:0];
    end
  end

  // sample capture, ratio product and per-step results
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      idx  <= in_idx;
      code <= code_in;
      rail <= (code_in == '0) || (code_in == FULL_SCALE);
      temp <= '0;
    end
    if (cmd.read) begin
      rprod <= r_eff * code;
    end
    if (cmd.store) begin
      unique case (cmd.step)
        tpc_pkg::STEP_LOG_NUM: log_a <= log_res;
        tpc_pkg::STEP_LOG_DEN: begin
          d <= tpc_pkg::D_W'($signed({1'b0, log_a})) -
               tpc_pkg::D_W'($signed({1'b0, log_res}));
        end
        tpc_pkg::STEP_MUL_L:  l  <= tpc_pkg::L_W'(mul_res);
        tpc_pkg::STEP_MUL_L2: l2 <= tpc_pkg::L2_W'(mul_res);
        tpc_pkg::STEP_MUL_L3: l3 <= tpc_pkg::L3_W'(mul_res);
        tpc_pkg::STEP_MUL_B:  y  <= 64'(coef_a) + mul_res;
        tpc_pkg::STEP_MUL_C:  y  <= y + mul_res;
        tpc_pkg::STEP_DIV:    temp <= t_final;
        default: begin
          temp <= temp;
        end
      endcase
    end
  end

  // per-probe state: presence flag and last temperature
  assign ram_we    = cmd.emit;
  assign now       = !rail;
  assign ram_wdata = {now, temp};

  tpc_ram #(.WIDTH(ST_W), .DEPTH(PROBES)) u_state (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (cmd.read),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // entries never written read as absent and zero
  assign was   = valid[addr] & ram_rdata[ST_W-1];
  assign old_t = valid[addr] ? $signed(ram_rdata[tpc_pkg::TEMP_W-1:0]) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else if (ram_we) begin
      valid[addr] <= 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      probe_id         <= idx;
      is_connected     <= now;
      temperature_f    <= temp;
      connect_event    <= now && !was;
      disconnect_event <= !now && was;
      change_event     <= now && (temp != old_t);
    end
  end
endmodule

[rtl/thermistor_probe_converter.sv]
// top level: configuration registers, controller and datapath
// depends on tpc_pkg, tpc_in_if, tpc_out_if, tpc_ctrl, tpc_dp
//
//  channel     dir  transfer when              payload
//  sample_in   in   valid && ready             probe_index, adc_code
//  result_out  out  valid && ready             probe_id, is_connected, temperature_f,
//                                              connect/disconnect/change events
//  apb         in   psel && penable && pwrite  paddr, pwdata (prdata on reads)
//
// a sample at either rail skips the computation and goes from the read state straight
// to the finish state; any other code goes through two log2 runs (normalize plus 24
// squaring steps each), five 3-digit multiplies and a 64-step restoring divider. one
// sample is in flight at a time; the next is taken while the previous result waits in
// the output register. a stalled result holds the last step. reset is synchronous,
// clears all probe state and restores register defaults.
module thermistor_probe_converter #(
  parameter int PROBES   = 8,
  parameter int ADC_BITS = 10
) (
  input  logic                          clk,
  input  logic                          rst,
  tpc_in_if.sink                        sample_in,
  tpc_out_if.source                     result_out,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [tpc_pkg::PADDR_W-1:0]   paddr,
  input  logic [tpc_pkg::PDATA_W-1:0]   pwdata,
  output logic [tpc_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);
  logic [tpc_pkg::SERIES_W-1:0]       series;
  logic signed [tpc_pkg::COEF_W-1:0]  coef_a;
  logic signed [tpc_pkg::COEF_W-1:0]  coef_b;
  logic signed [tpc_pkg::COEF_W-1:0]  coef_c;
  logic [tpc_pkg::REG_W-1:0]          reg_sel;
  logic                               wr;
  tpc_pkg::tpc_cmd_t                  cmd;
  tpc_pkg::tpc_status_t               status;

  assign pready  = 1'b1;
  assign reg_sel = paddr[tpc_pkg::PADDR_W-1 -: tpc_pkg::REG_W];
  assign wr      = psel && penable && pwrite;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      series <= tpc_pkg::SERIES_RESET;
      coef_a <= '0;
      coef_b <= '0;
      coef_c <= '0;
    end else if (wr) begin
      unique case (reg_sel)
        tpc_pkg::REG_SERIES: series <= pwdata[tpc_pkg::SERIES_W-1:0];
        tpc_pkg::REG_COEF_A: coef_a <= $signed(pwdata[tpc_pkg::COEF_W-1:0]);
        tpc_pkg::REG_COEF_B: coef_b <= $signed(pwdata[tpc_pkg::COEF_W-1:0]);
        tpc_pkg::REG_COEF_C: coef_c <= $signed(pwdata[tpc_pkg::COEF_W-1:0]);
        default: begin
          series <= series;
        end
      endcase
    end
  end

  // register readback
  always_comb begin
    unique case (reg_sel)
      tpc_pkg::REG_SERIES: prdata = tpc_pkg::PDATA_W'(series);
      tpc_pkg::REG_COEF_A: prdata = tpc_pkg::PDATA_W'(unsigned'(coef_a));
      tpc_pkg::REG_COEF_B: prdata = tpc_pkg::PDATA_W'(unsigned'(coef_b));
      tpc_pkg::REG_COEF_C: prdata = tpc_pkg::PDATA_W'(unsigned'(coef_c));
      default:             prdata = '0;
    endcase
  end

  tpc_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (sample_in.valid),
    .in_ready  (sample_in.ready),
    .out_valid (result_out.valid),
    .out_ready (result_out.ready),
    .status    (status),
    .cmd       (cmd)
  );

  tpc_dp #(.PROBES(PROBES), .ADC_BITS(ADC_BITS)) u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_idx           (sample_in.probe_index),
    .in_code          (sample_in.adc_code),
    .series           (series),
    .coef_a           (coef_a),
    .coef_b           (coef_b),
    .coef_c           (coef_c),
    .probe_id         (result_out.probe_id),
    .is_connected     (result_out.is_connected),
    .temperature_f    (result_out.temperature_f),
    .connect_event    (result_out.connect_event),
    .disconnect_event (result_out.disconnect_event),
    .change_event     (result_out.change_event)
  );
endmodule
